FILE: rtl/sabs_pkg.sv
// sabs_pkg: shared types and constants for the sorted array bound search block
// command codes, field widths, controller states and controller/datapath structs
// no dependencies
`default_nettype none

package sabs_pkg;

  localparam int unsigned CMD_W = 2;   // command field
  localparam int unsigned IDX_W = 10;  // load index field
  localparam int unsigned POS_W = 11;  // position field and entry count register

  localparam int unsigned OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EXACT = 2'd1,
    CMD_LOWER = 2'd2,
    CMD_UPPER = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ISSUE   = 4'b0010,
    ST_COMPARE = 4'b0100,
    ST_FINISH  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_we;  // write the incoming entry
    logic start;    // latch key and mode, open the window
    logic issue;    // read the midpoint entry
    logic compare;  // compare read entry with key, narrow the window
    logic finish;   // result taken into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_open;  // window not empty and no exact hit yet
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/sabs_ram.sv
// sabs_ram: generic single-port RAM with registered read data
// width and depth set by parameters; no package dependency
`default_nettype none

module sabs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: rtl/sabs_ctrl.sv
// sabs_ctrl: controller state machine for the bound search
// depends on sabs_pkg (states, command codes, command and status structs)
`default_nettype none

module sabs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire sabs_pkg::cmd_t      in_command,
  input  wire logic                out_free,
  input  wire sabs_pkg::dp_status_t status,
  output sabs_pkg::ctrl_cmd_t      cmd,
  output logic                     in_ready
);

  import sabs_pkg::*;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (status.win_open) begin
          cmd.issue = 1'b1;
          state_nxt = ST_COMPARE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_ISSUE;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sabs_datapath.sv
// sabs_datapath: entry store, search window, midpoint and compare logic
// depends on sabs_pkg and sabs_ram
`default_nettype none

module sabs_datapath #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sabs_pkg::POS_W-1:0]    cfg_wr_data,
  input  wire sabs_pkg::ctrl_cmd_t           cmd,
  input  wire sabs_pkg::cmd_t                in_command,
  input  wire logic [sabs_pkg::IDX_W-1:0]    in_load_index,
  input  wire logic [DATA_WIDTH-1:0]         in_value,
  output sabs_pkg::dp_status_t               status,
  output logic [sabs_pkg::POS_W-1:0]         res_position,
  output logic                               res_found
);

  import sabs_pkg::*;

  localparam int unsigned AW        = $clog2(STORE_DEPTH);
  localparam int unsigned POS_MAX   = (1 << POS_W) - 1;
  localparam int unsigned DEPTH_CAP = (STORE_DEPTH < POS_MAX) ? STORE_DEPTH : POS_MAX;
  localparam logic [POS_W-1:0] CAP  = POS_W'(DEPTH_CAP);

  logic [POS_W-1:0]      cnt_r;
  logic [POS_W-1:0]      n_r, low_r, high_r, mid_r;
  logic [POS_W-1:0]      low_nxt, high_nxt;
  logic                  hit_r, hit_nxt;
  cmd_t                  mode_r;
  logic [DATA_WIDTH-1:0] key_r;

  logic [POS_W-1:0]      n_sat;
  logic [POS_W:0]        sum;
  logic [POS_W-1:0]      mid_c;
  logic [POS_W-1:0]      mid_inc;
  logic [AW-1:0]         ram_addr;
  logic                  ram_we;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  eq, gt;
  logic                  go_left;
  logic                  idx_ok;

  // entry count saturates at the store depth
  assign n_sat = (cnt_r > CAP) ? CAP : cnt_r;

  // exact search probes the middle of the closed window, bounds the half-open one
  assign sum   = {1'b0, low_r} + {1'b0, high_r};
  assign mid_c = (mode_r == CMD_EXACT) ? POS_W'((sum - 1'b1) >> 1) : POS_W'(sum >> 1);
  assign mid_inc = mid_r + 1'b1;

  assign idx_ok   = (32'(in_load_index) < STORE_DEPTH);
  assign ram_we   = cmd.load_we && idx_ok;
  assign ram_addr = cmd.issue ? AW'(mid_c) : AW'(in_load_index);

  sabs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (in_value),
    .rdata_r (rdata)
  );

  assign eq = (rdata == key_r);
  assign gt = ($signed(rdata) > $signed(key_r));

  always_comb begin
    unique case (mode_r)
      CMD_UPPER: go_left = gt;
      CMD_LOWER: go_left = gt || eq;
      default:   go_left = gt;
    endcase
  end

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    hit_nxt  = hit_r;
    if (cmd.start) begin
      low_nxt  = '0;
      high_nxt = n_sat;
      hit_nxt  = 1'b0;
    end else if (cmd.compare) begin
      if ((mode_r == CMD_EXACT) && eq) begin
        hit_nxt = 1'b1;
      end else if (go_left) begin
        high_nxt = mid_r;
      end else begin
        low_nxt = mid_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
      low_r  <= low_nxt;
      high_r <= high_nxt;
      hit_r  <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_command;
      key_r  <= in_value;
      n_r    <= n_sat;
    end
    if (cmd.issue) begin
      mid_r <= mid_c;
    end
  end

  assign status.win_open = (low_r < high_r) && !hit_r;

  always_comb begin
    if (mode_r == CMD_EXACT) begin
      res_position = hit_r ? mid_r : '0;
      res_found    = hit_r;
    end else begin
      res_position = low_r;
      res_found    = (low_r < n_r);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_array_bound_search.sv
// sorted_array_bound_search: top level, stream ports and output register
// depends on sabs_pkg, sabs_ctrl, sabs_datapath (and sabs_ram below it)
//
// Holds an ascending array of signed DATA_WIDTH-bit entries in a single-port
// RAM and searches the first entry_count of them by halving. A load transaction
// (command 0) writes one entry and gives no result; a load index at
// or beyond STORE_DEPTH is dropped. A search transaction gives exactly one result:
// exact (command 1) returns the matching position with found set, or 0 with found
// clear; lower bound (2) returns the first entry >= key and upper bound (3) the
// first entry > key, each returning entry_count with found clear when nothing
// qualifies. entry_count above STORE_DEPTH is clamped. A search makes at most
// ceil(log2(n+1)) probes, so 11 for 1024 entries; each probe is a registered RAM
// read followed by a compare, and the RAM port is the limit. One search is in
// flight at a time; a finished result waits in the output register while the
// next transaction is accepted. Entries are not cleared at reset: reading an
// entry never loaded gives undefined data. Write entry_count only while the
// block is idle.
`default_nettype none

module sorted_array_bound_search #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration: entry_count
  input  wire logic                              cfg_wr_en,
  input  wire logic [sabs_pkg::POS_W-1:0]        cfg_wr_data,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // in_tdata from bit 0: load_index, value, zero fill
  input  wire logic [((sabs_pkg::IDX_W + DATA_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: command
  input  wire logic [sabs_pkg::CMD_W-1:0]        in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tdata from bit 0: position, zero fill
  output logic [sabs_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // out_tuser: found
  output logic [0:0]                             out_tuser
);

  import sabs_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  cmd_t                  in_command;
  logic [IDX_W-1:0]      in_load_index;
  logic [DATA_WIDTH-1:0] in_value;
  logic [POS_W-1:0]      res_position;
  logic                  res_found;
  logic                  out_free;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]      out_pos_r;
  logic                  out_found_r;

  // unpack the input transaction
  assign in_command    = cmd_t'(in_tuser);
  assign in_load_index = in_tdata[IDX_W-1:0];
  assign in_value      = in_tdata[IDX_W +: DATA_WIDTH];

  // result slot can take a new result when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  sabs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_command),
    .out_free   (out_free),
    .status     (status),
    .cmd        (cmd),
    .in_ready   (in_tready)
  );

  sabs_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (cmd),
    .in_command    (in_command),
    .in_load_index (in_load_index),
    .in_value      (in_value),
    .status        (status),
    .res_position  (res_position),
    .res_found     (res_found)
  );

  // valid sets on finish, clears once the downstream side takes the transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_pos_r   <= res_position;
      out_found_r <= res_found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_pos_r);
  assign out_tuser  = out_found_r;

  // a finished search never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result register overwritten while pending");

  // a search starts only on an accepted non-load transaction
  a_start_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (in_tvalid && in_tready && (in_command != CMD_LOAD)))
    else $error("search started without an accepted search transaction");

  // no new transaction is taken in the cycle after a search starts
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_tready)
    else $error("input accepted while a search is running");

endmodule

`default_nettype wire

FILE: verif/sorted_array_bound_search_test.sv
// sorted_array_bound_search_test: self-checking testbench for the sorted array bound search
// drives load and search transactions with random hold-offs and checks each result in order
// depends on sabs_pkg and sorted_array_bound_search
module sorted_array_bound_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sabs_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IN_TDATA_W = ((IDX_W + WORD_W + 7) / 8) * 8;
  // margin left after the last result so the block has settled
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS = 60;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // one search result as the block reports it
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } bound_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [POS_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata from bit 0: load_index, value, zero fill
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  // in_tuser: command
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata from bit 0: position, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  // out_tuser: found
  logic [0:0]            out_tuser;

  // mirror of the block: entry store and entry_count register
  logic signed [WORD_W-1:0] entry_mirror [DEPTH];
  int                       count_mirror = 0;

  bound_result_t pending_results [$];
  int            errors = 0;
  int            item_count = 0;
  int            idle_max = 4;   // longest hold-off per transaction on either side
  int            out_stall = 0;  // cycles the receiver still holds off the current result

  sorted_array_bound_search i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // number of entries a search covers, entry_count clamped to the store depth
  function automatic int active_entries();
    return (count_mirror > DEPTH) ? DEPTH : count_mirror;
  endfunction

  // halving search over the mirrored store, same probe order as the hardware
  function automatic bound_result_t predict_search(cmd_t cmd, logic signed [WORD_W-1:0] key);
    int                       n;
    int                       lo;
    int                       hi;
    int                       mid;
    logic signed [WORD_W-1:0] probe;
    bound_result_t            res;
    n = active_entries();
    lo = 0;
    hi = n;
    res.position = '0;
    res.found = 1'b0;
    if (cmd == CMD_EXACT) begin
      // closed window [lo, hi-1], stop at the first probe that matches
      while (lo < hi && !res.found) begin
        mid = (lo + hi - 1) >> 1;
        probe = entry_mirror[mid];
        if (probe == key) begin
          res.position = mid[POS_W-1:0];
          res.found = 1'b1;
        end else if (probe > key) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end else begin
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        probe = entry_mirror[mid];
        if ((cmd == CMD_UPPER) ? (probe > key) : (probe >= key)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      // nothing qualifies or empty array: position is the entry count
      res.position = lo[POS_W-1:0];
      res.found = (lo < n);
    end
    return res;
  endfunction

  // search key near the stored data: hits, near misses, extremes and noise
  function automatic logic signed [WORD_W-1:0] pick_key();
    int                       n;
    logic signed [WORD_W-1:0] key;
    n = active_entries();
    key = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: if (n > 0) key = entry_mirror[$urandom_range(0, n - 1)];
      3:       if (n > 0) key = entry_mirror[$urandom_range(0, n - 1)] + 1;
      4:       if (n > 0) key = entry_mirror[$urandom_range(0, n - 1)] - 1;
      5:       key = WORD_MIN;
      6:       key = WORD_MAX;
      default: ;
    endcase
    return key;
  endfunction

  // send one transaction after a random hold-off; valid stays high for back-to-back items
  task automatic send_item(cmd_t cmd, int idx, logic signed [WORD_W-1:0] value);
    int                    gap;
    logic [IN_TDATA_W-1:0] word;
    gap = $urandom_range(0, idle_max);
    word = '0;
    word[IDX_W-1:0] = idx[IDX_W-1:0];
    word[IDX_W +: WORD_W] = value;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_LOAD) begin
      entry_mirror[idx] = value;
    end else begin
      pending_results.push_back(predict_search(cmd, value));
    end
    item_count++;
  endtask

  // stop sending and let the block drain; a trailing load may still be in progress
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(int count);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count[POS_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_mirror = count & ((1 << POS_W) - 1);
  endtask

  // load entries 0..n-1 in ascending order; step_max sets spread and duplicate rate
  task automatic load_sorted(int n, longint start, longint step_max);
    longint acc;
    acc = start;
    for (int i = 0; i < n; i++) begin
      if (acc > longint'(WORD_MAX)) acc = longint'(WORD_MAX);
      send_item(CMD_LOAD, i, acc[WORD_W-1:0]);
      acc += longint'($urandom_range(0, int'(step_max)));
    end
  endtask

  // result side: random hold-off after each result appears, check against oldest prediction
  always @(posedge clk) begin
    bound_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, position %0d found %0b", $time,
                 out_tdata[POS_W-1:0], out_tuser[0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[POS_W-1:0] !== want.position) begin
          $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                   want.position, out_tdata[POS_W-1:0]);
          errors++;
        end
        if (out_tuser[0] !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b", $time,
                   want.found, out_tuser[0]);
          errors++;
        end
      end
      out_stall = $urandom_range(0, idle_max);
    end else if (out_stall > 0 && out_tvalid) begin
      out_stall--;
    end
    out_tready <= (out_stall == 0);
  end

  // reset value of entry_count is zero: every search sees an empty array
  task automatic test_empty_array();
    send_item(CMD_EXACT, 0, 32'sd0);
    send_item(CMD_LOWER, 0, WORD_MIN);
    send_item(CMD_UPPER, 0, WORD_MAX);
    send_item(CMD_LOWER, 0, WORD_MAX);
  endtask

  // five entries with both word extremes and a duplicated key
  task automatic test_directed_extremes();
    send_item(CMD_LOAD, 0, WORD_MIN);
    send_item(CMD_LOAD, 1, -32'sd5);
    send_item(CMD_LOAD, 2, 32'sd7);
    send_item(CMD_LOAD, 3, 32'sd7);
    send_item(CMD_LOAD, 4, WORD_MAX);
    // top index, all ones
    send_item(CMD_LOAD, DEPTH - 1, -32'sd1);
    set_entry_count(5);
    send_item(CMD_EXACT, 0, WORD_MIN);
    send_item(CMD_EXACT, 0, WORD_MAX);
    // duplicate key: the first matching probe wins
    send_item(CMD_EXACT, 0, 32'sd7);
    // exact miss reports position zero
    send_item(CMD_EXACT, 0, 32'sd0);
    send_item(CMD_LOWER, 0, WORD_MIN);
    send_item(CMD_LOWER, 0, 32'sd7);
    send_item(CMD_LOWER, 0, -32'sd4);
    send_item(CMD_LOWER, 0, WORD_MAX);
    send_item(CMD_UPPER, 0, WORD_MIN);
    send_item(CMD_UPPER, 0, 32'sd7);
    // no entry above the largest word: bound is the entry count
    send_item(CMD_UPPER, 0, WORD_MAX);
  endtask

  // whole store loaded; entry_count at depth, above depth (clamped), one below, and zero
  task automatic test_full_array();
    int counts [4];
    counts = '{DEPTH, (1 << POS_W) - 1, DEPTH - 1, 0};
    load_sorted(DEPTH, longint'(WORD_MIN), longint'(1 << 23));
    foreach (counts[c]) begin
      set_entry_count(counts[c]);
      repeat (12) send_item(cmd_t'($urandom_range(1, 3)), $urandom_range(0, DEPTH - 1),
                            pick_key());
    end
  endtask

  // phases of sorted loads, one entry_count write and searches, with some stray loads
  task automatic test_random_phases();
    int     first_item;
    int     n;
    longint step_max;
    longint start;
    first_item = item_count;
    while (item_count - first_item < RANDOM_ITEMS) begin
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      case ($urandom_range(0, 15))
        0:       n = 0;
        1:       n = (DEPTH - 1) + $urandom_range(0, 1) + (($urandom_range(0, 2) == 0) ? 1023 : 0);
        2, 3:    n = $urandom_range(33, 200);
        default: n = $urandom_range(1, 32);
      endcase
      if (n <= 200) begin
        case ($urandom_range(0, 3))
          0:       step_max = 2;
          1:       step_max = 1000;
          2:       step_max = 1 << 20;
          default: step_max = 1 << 24;
        endcase
        start = ($urandom_range(0, 3) == 0) ? longint'(WORD_MIN) :
                longint'($urandom_range(0, 32'hffff_fff0)) - 64'sd2147483648;
        load_sorted(n, start, step_max);
      end
      set_entry_count(n);
      repeat ($urandom_range(4, 16)) begin
        // occasional stray load may break the ordering inside the window
        if ($urandom_range(0, 24) == 0) begin
          send_item(CMD_LOAD, $urandom_range(0, DEPTH - 1), $urandom);
        end
        send_item(cmd_t'($urandom_range(1, 3)), $urandom_range(0, DEPTH - 1), pick_key());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_array();
    test_directed_extremes();
    test_full_array();
    test_random_phases();
    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/sabs_pkg.sv
rtl/sabs_ram.sv
rtl/sabs_ctrl.sv
rtl/sabs_datapath.sv
rtl/sorted_array_bound_search.sv
verif/sorted_array_bound_search_test.sv
